FILE: rtl/pdrf_pkg.sv
package pdrf_pkg;

  localparam int unsigned MOM_COUNT = 3;

  localparam logic [0:0] REG_NORMAL_AXIS = 1'd0;

  typedef struct packed {
    logic        [30:0] rho_left;
    logic signed [31:0] vn_left;
    logic signed [31:0] mom1_left;
    logic signed [31:0] mom2_left;
    logic signed [31:0] mom3_left;
    logic        [30:0] rho_right;
    logic signed [31:0] vn_right;
    logic signed [31:0] mom1_right;
    logic signed [31:0] mom2_right;
    logic signed [31:0] mom3_right;
    logic        [30:0] speed_in;
    logic               last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] flux_mass;
    logic signed [31:0] flux_mom1;
    logic signed [31:0] flux_mom2;
    logic signed [31:0] flux_mom3;
    logic        [30:0] speed_out;
    logic               last_out;
  } out_word_t;

  typedef struct packed {
    logic adv;
    logic src_valid;
  } pipe_ctl_t;

endpackage

FILE: rtl/pdrf_pipe.sv
module pdrf_pipe #(
  parameter int COMPONENT_COUNT = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pdrf_pkg::pipe_ctl_t ctl,
  input  pdrf_pkg::in_word_t  src,
  input  logic [1:0]          axis,
  output logic                out_valid,
  output pdrf_pkg::out_word_t out_data
);

  localparam int unsigned NM = pdrf_pkg::MOM_COUNT;
  localparam logic [1:0] AXIS_MAX = 2'(COMPONENT_COUNT - 1);
  localparam logic [1:0] SGN_ZERO = 2'd0;
  localparam logic [1:0] SGN_POS  = 2'd1;
  localparam logic [1:0] SGN_NEG  = 2'd2;

  typedef logic signed [31:0] s32_t;

  typedef struct packed {
    logic [30:0]       rl;
    logic [30:0]       rr;
    logic [31:0]       avl;
    logic [31:0]       avr;
    s32_t              vl;
    s32_t              vr;
    s32_t [NM-1:0]     ml;
    s32_t [NM-1:0]     mr;
    s32_t              fl0;
    s32_t              fr0;
    logic [30:0]       spd;
    logic              last;
    logic              vac;
    logic [1:0]        sgn;
    logic              cmp;
  } st1_t;

  typedef struct packed {
    logic [30:0]                    rl;
    logic [30:0]                    rr;
    logic [63:0]                    sql;
    logic [63:0]                    sqr;
    logic signed [NM-1:0][63:0]     pl;
    logic signed [NM-1:0][63:0]     pr;
    s32_t                           fl0;
    s32_t                           fr0;
    s32_t                           fav0;
    logic [30:0]                    spd;
    logic                           last;
    logic                           vac;
    logic [1:0]                     sgn;
    logic                           cmp;
  } st2_t;

  typedef struct packed {
    logic [60:0]       tl;
    logic [62:0]       bl;
    logic [60:0]       tr;
    logic [62:0]       br;
    s32_t [NM:0]       cl;
    s32_t [NM:0]       cr;
    s32_t [NM:0]       ca;
    logic [30:0]       spd;
    logic              last;
    logic              vac;
    logic [1:0]        sgn;
    logic              cmp;
  } st3_t;

  typedef struct packed {
    logic [92:0]       el;
    logic [92:0]       er;
    s32_t [NM:0]       cl;
    s32_t [NM:0]       cr;
    s32_t [NM:0]       ca;
    logic [30:0]       spd;
    logic              last;
    logic              vac;
    logic [1:0]        sgn;
    logic              cmp;
  } st4_t;

  function automatic s32_t sat48(input logic signed [47:0] x);
    s32_t r;
    if (x[47:31] == {17{x[47]}}) begin
      r = x[31:0];
    end else if (x[47]) begin
      r = {1'b1, 31'd0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  st1_t st1_nxt, st1_r;
  st2_t st2_nxt, st2_r;
  st3_t st3_nxt, st3_r;
  st4_t st4_nxt, st4_r;
  pdrf_pkg::out_word_t out_nxt, out_r;
  logic v1_r, v2_r, v3_r, v4_r, vo_r;

  always_comb begin
    logic [1:0]  ax;
    logic [31:0] avl, avr, mx;
    logic        sl_nz, sr_nz;
    st1_nxt = '0;
    ax = (axis > AXIS_MAX) ? AXIS_MAX : axis;
    st1_nxt.rl = src.rho_left;
    st1_nxt.rr = src.rho_right;
    st1_nxt.vl = src.vn_left;
    st1_nxt.vr = src.vn_right;
    st1_nxt.ml[0] = src.mom1_left;
    st1_nxt.ml[1] = src.mom2_left;
    st1_nxt.ml[2] = src.mom3_left;
    st1_nxt.mr[0] = src.mom1_right;
    st1_nxt.mr[1] = src.mom2_right;
    st1_nxt.mr[2] = src.mom3_right;
    st1_nxt.fl0 = st1_nxt.ml[ax];
    st1_nxt.fr0 = st1_nxt.mr[ax];
    avl = src.vn_left[31] ? (~src.vn_left + 32'd1) : src.vn_left;
    avr = src.vn_right[31] ? (~src.vn_right + 32'd1) : src.vn_right;
    st1_nxt.avl = avl;
    st1_nxt.avr = avr;
    mx = {1'b0, src.speed_in};
    if (avl > mx) begin
      mx = avl;
    end
    if (avr > mx) begin
      mx = avr;
    end
    st1_nxt.spd = mx[31] ? {31{1'b1}} : mx[30:0];
    st1_nxt.last = src.last_in;
    st1_nxt.vac = src.vn_left[31] && !src.vn_right[31] && (src.vn_right != '0);
    sl_nz = (src.rho_left != '0) && (src.vn_left != '0);
    sr_nz = (src.rho_right != '0) && (src.vn_right != '0);
    st1_nxt.cmp = 1'b0;
    if (!sl_nz) begin
      st1_nxt.sgn = !sr_nz ? SGN_ZERO : (src.vn_right[31] ? SGN_NEG : SGN_POS);
    end else begin
      st1_nxt.sgn = src.vn_left[31] ? SGN_NEG : SGN_POS;
      st1_nxt.cmp = sr_nz && (src.vn_left[31] != src.vn_right[31]);
    end
  end

  always_comb begin
    logic signed [32:0] ms;
    st2_nxt = '0;
    st2_nxt.rl = st1_r.rl;
    st2_nxt.rr = st1_r.rr;
    st2_nxt.sql = st1_r.avl * st1_r.avl;
    st2_nxt.sqr = st1_r.avr * st1_r.avr;
    for (int c = 0; c < NM; c++) begin
      st2_nxt.pl[c] = st1_r.ml[c] * st1_r.vl;
      st2_nxt.pr[c] = st1_r.mr[c] * st1_r.vr;
    end
    st2_nxt.fl0 = st1_r.fl0;
    st2_nxt.fr0 = st1_r.fr0;
    ms = 33'(st1_r.fl0) + 33'(st1_r.fr0);
    st2_nxt.fav0 = ms[32:1];
    st2_nxt.spd = st1_r.spd;
    st2_nxt.last = st1_r.last;
    st2_nxt.vac = st1_r.vac;
    st2_nxt.sgn = st1_r.sgn;
    st2_nxt.cmp = st1_r.cmp;
  end

  always_comb begin
    logic [62:0]        tl, tr;
    logic signed [64:0] sum;
    logic signed [63:0] shl, shr;
    st3_nxt = '0;
    tl = st2_r.rl * st2_r.sql[63:32];
    tr = st2_r.rr * st2_r.sqr[63:32];
    st3_nxt.tl = tl[60:0];
    st3_nxt.tr = tr[60:0];
    st3_nxt.bl = st2_r.rl * st2_r.sql[31:0];
    st3_nxt.br = st2_r.rr * st2_r.sqr[31:0];
    st3_nxt.cl[0] = st2_r.fl0;
    st3_nxt.cr[0] = st2_r.fr0;
    st3_nxt.ca[0] = st2_r.fav0;
    for (int c = 0; c < NM; c++) begin
      shl = st2_r.pl[c] >>> 16;
      shr = st2_r.pr[c] >>> 16;
      sum = 65'($signed(st2_r.pl[c])) + 65'($signed(st2_r.pr[c]));
      sum = sum >>> 17;
      st3_nxt.cl[c+1] = sat48(shl[47:0]);
      st3_nxt.cr[c+1] = sat48(shr[47:0]);
      st3_nxt.ca[c+1] = sat48(sum[47:0]);
    end
    st3_nxt.spd = st2_r.spd;
    st3_nxt.last = st2_r.last;
    st3_nxt.vac = st2_r.vac;
    st3_nxt.sgn = st2_r.sgn;
    st3_nxt.cmp = st2_r.cmp;
  end

  always_comb begin
    st4_nxt = '0;
    st4_nxt.el = {st3_r.tl, 32'd0} + 93'(st3_r.bl);
    st4_nxt.er = {st3_r.tr, 32'd0} + 93'(st3_r.br);
    st4_nxt.cl = st3_r.cl;
    st4_nxt.cr = st3_r.cr;
    st4_nxt.ca = st3_r.ca;
    st4_nxt.spd = st3_r.spd;
    st4_nxt.last = st3_r.last;
    st4_nxt.vac = st3_r.vac;
    st4_nxt.sgn = st3_r.sgn;
    st4_nxt.cmp = st3_r.cmp;
  end

  always_comb begin
    logic [1:0]  sgn;
    s32_t [NM:0] res;
    sgn = st4_r.sgn;
    if (st4_r.cmp) begin
      if (st4_r.el < st4_r.er) begin
        sgn = (st4_r.sgn == SGN_POS) ? SGN_NEG : SGN_POS;
      end else if (st4_r.el == st4_r.er) begin
        sgn = SGN_ZERO;
      end
    end
    case (sgn)
      SGN_POS: res = st4_r.cl;
      SGN_NEG: res = st4_r.cr;
      default: res = st4_r.ca;
    endcase
    if (st4_r.vac) begin
      res = '0;
    end
    for (int c = 0; c < NM; c++) begin
      if (c >= COMPONENT_COUNT) begin
        res[c+1] = '0;
      end
    end
    out_nxt.flux_mass = res[0];
    out_nxt.flux_mom1 = res[1];
    out_nxt.flux_mom2 = res[2];
    out_nxt.flux_mom3 = res[3];
    out_nxt.speed_out = st4_r.spd;
    out_nxt.last_out = st4_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (ctl.adv) begin
      v1_r <= ctl.src_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vo_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      st1_r <= st1_nxt;
      st2_r <= st2_nxt;
      st3_r <= st3_nxt;
      st4_r <= st4_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

  a_vac_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && st4_r.vac && ctl.adv |=> vo_r && out_r.flux_mass == '0
      && out_r.flux_mom1 == '0)
    else $error("vacuum word gave nonzero flux");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.adv |=> $stable(vo_r) && $stable(v4_r) && $stable(v1_r))
    else $error("pipeline valid moved while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && !ctl.adv |=> vo_r && $stable(out_r))
    else $error("output word changed while stalled");

endmodule

FILE: rtl/pressureless_dust_riemann_flux_top.sv
// Pressureless dust Riemann flux, one cell interface per word.
// Input channel in_valid/in_ready/in_data carries left and right density,
// normal velocity, three momenta, the running maximum speed and a row marker.
// Output channel out_valid/out_ready/out_data returns the mass flux, three
// momentum fluxes, the updated maximum speed and the row marker.
// The normal momentum component is chosen by the normal_axis register at
// APB address 0; write it only while the block is idle.
// Throughput is one word per clock while the output is not stalled; the
// datapath is five register stages (abs/sign setup, 32x32 multiplies,
// density multiplies, 93-bit combine, compare/select into the output
// register).
// While out_valid is high and out_ready low the whole pipeline holds; a
// one-word skid register on the input absorbs the word taken in that cycle,
// so in_ready is a plain register, never combinationally tied to out_ready.
// Synchronous reset empties the pipeline and the skid register and sets
// normal_axis to 0.
module pressureless_dust_riemann_flux_top #(
  parameter int COMPONENT_COUNT = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pdrf_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pdrf_pkg::out_word_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [1:0]          axis_r, axis_nxt;
  logic                skid_v_r, skid_v_nxt;
  pdrf_pkg::in_word_t  skid_r;
  pdrf_pkg::in_word_t  src;
  pdrf_pkg::pipe_ctl_t ctl;
  logic                adv;
  logic                reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == pdrf_pkg::REG_NORMAL_AXIS);
  assign prdata  = reg_hit ? {30'd0, axis_r} : 32'd0;

  always_comb begin
    axis_nxt = axis_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      axis_nxt = pwdata[1:0];
    end
  end

  assign adv           = !out_valid || out_ready;
  assign in_ready      = !skid_v_r;
  assign src           = skid_v_r ? skid_r : in_data;
  assign ctl.adv       = adv;
  assign ctl.src_valid = skid_v_r || in_valid;

  always_comb begin
    skid_v_nxt = skid_v_r;
    if (adv) begin
      skid_v_nxt = 1'b0;
    end else if (in_valid && in_ready) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r   <= '0;
      skid_v_r <= 1'b0;
    end else begin
      axis_r   <= axis_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_valid && in_ready) begin
      skid_r <= in_data;
    end
  end

  pdrf_pipe #(
    .COMPONENT_COUNT(COMPONENT_COUNT)
  ) u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .src      (src),
    .axis     (axis_r),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !adv |=> skid_v_r && skid_r == $past(in_data))
    else $error("stalled input word not caught");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !adv |=> skid_v_r && $stable(skid_r))
    else $error("skid word lost during stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !skid_v_r && axis_r == '0)
    else $error("reset left state behind");

endmodule
